// ===== rtl/skl_pkg.sv =====
// Shared types and constants for the sorted key list.
package skl_pkg;

  localparam int CAPACITY = 16;
  localparam int KEY_W    = 32;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int POS_W    = 4;
  localparam int COUNT_W  = 5;

  typedef logic signed [KEY_W-1:0] key_t;
  typedef logic [IDX_W-1:0]        idx_t;
  typedef logic [CNT_W-1:0]        cnt_t;

  typedef enum logic {
    KIND_INSERT = 1'b0,
    KIND_DELETE = 1'b1
  } kind_t;

  typedef enum logic [1:0] {
    ST_INSERTED  = 2'd0,
    ST_DELETED   = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_FULL      = 2'd3
  } status_t;

  // Broadcast control from the sequencer to every cell.
  typedef struct packed {
    logic load;    // capture compare flags against the incoming key
    logic ins_en;  // apply insert shift this cycle
    logic del_en;  // apply delete shift this cycle
    logic is_del;  // operation held in the cells is a delete
  } cell_ctrl_t;

endpackage

// ===== rtl/skl_if.sv =====
// Valid/ready channel interfaces for operation input and result output.
interface skl_in_if;
  logic               valid;
  logic               ready;
  skl_pkg::kind_t     kind;
  skl_pkg::key_t      key;

  modport source (output valid, output kind, output key, input ready);
  modport sink   (input valid, input kind, input key, output ready);
endinterface

interface skl_out_if;
  logic                           valid;
  logic                           ready;
  skl_pkg::status_t               status;
  logic [skl_pkg::POS_W-1:0]      position;
  logic [skl_pkg::COUNT_W-1:0]    entry_count;

  modport source (output valid, output status, output position, output entry_count,
                  input ready);
  modport sink   (input valid, input status, input position, input entry_count,
                  output ready);
endinterface

// ===== rtl/skl_cell.sv =====
// One list slot: holds a key, compares it with the incoming key, shifts left or right.
module skl_cell (
  input  logic                clk,
  input  skl_pkg::idx_t       idx,
  input  skl_pkg::cell_ctrl_t ctrl,
  input  skl_pkg::key_t       in_key,
  input  skl_pkg::key_t       ins_key,
  input  skl_pkg::cnt_t       count,
  input  skl_pkg::key_t       left_key,
  input  skl_pkg::key_t       right_key,
  input  logic                left_h,
  input  logic                left_d,
  output skl_pkg::key_t       key_o,
  output logic                h_o,
  output logic                d_o,
  output logic                bnd_o
);

  skl_pkg::key_t key_r;
  logic          gt_r;     // incoming key greater than this entry
  logic          eq_r;
  logic          valid_r;  // slot holds a live key
  logic          here;

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      gt_r    <= in_key > key_r;
      eq_r    <= in_key == key_r;
      valid_r <= skl_pkg::cnt_t'(idx) < count;
    end
  end

  // Insert point: front slot takes the key when the list is empty or its key is
  // larger; later slots take it at the first entry not below it.
  always_comb begin
    if (idx == '0) begin
      here = !valid_r || (!gt_r && !eq_r);
    end else begin
      here = !valid_r || !gt_r;
    end
  end

  assign h_o   = left_h | here;
  assign d_o   = left_d | (valid_r & eq_r);
  assign bnd_o = ctrl.is_del ? (d_o & !left_d) : (h_o & !left_h);
  assign key_o = key_r;

  always_ff @(posedge clk) begin
    if (ctrl.ins_en && h_o) begin
      key_r <= left_h ? left_key : ins_key;
    end else if (ctrl.del_en && d_o) begin
      key_r <= right_key;
    end
  end

endmodule

// ===== rtl/sorted_key_list_insert_delete.sv =====
// Bounded ascending key list built from a row of compare-and-shift cells.
// The input beat loads the cell compare flags; S_EXEC applies the shift and registers the result.
// The cells hold one operation at a time; no new input is taken while in S_EXEC.
// Input is taken while a finished result waits only if that result leaves the same cycle.
// Reset: synchronous active-low rst_n empties the list and drops any pending result;
// no clearing pass, slots beyond the count are never read.
module sorted_key_list_insert_delete (
  input  logic       clk,
  input  logic       rst_n,
  skl_in_if.sink     in_ch,
  skl_out_if.source  out_ch
);

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_t;

  state_t                  state_r;
  skl_pkg::kind_t          kind_r;
  skl_pkg::key_t           key_r;
  skl_pkg::cnt_t           count_r;
  logic                    out_valid_r;
  skl_pkg::status_t        status_r;
  logic [skl_pkg::POS_W-1:0]   pos_r;
  logic [skl_pkg::COUNT_W-1:0] entry_cnt_r;

  skl_pkg::cell_ctrl_t     ctrl;
  skl_pkg::key_t           cell_key [skl_pkg::CAPACITY];
  logic [skl_pkg::CAPACITY-1:0] h_vec;
  logic [skl_pkg::CAPACITY-1:0] d_vec;
  logic [skl_pkg::CAPACITY-1:0] bnd_vec;
  logic                    accept;
  logic                    full;
  logic                    found;
  skl_pkg::idx_t           bnd_idx;
  skl_pkg::status_t        status_nxt;
  skl_pkg::cnt_t           count_nxt;
  skl_pkg::idx_t           pos_nxt;

  assign in_ch.ready = (state_r == S_IDLE) && (!out_valid_r || out_ch.ready);
  assign accept      = in_ch.valid && in_ch.ready;
  assign full        = count_r == skl_pkg::cnt_t'(skl_pkg::CAPACITY);
  assign found       = d_vec[skl_pkg::CAPACITY-1];

  always_comb begin
    ctrl.load   = accept;
    ctrl.is_del = kind_r == skl_pkg::KIND_DELETE;
    ctrl.ins_en = (state_r == S_EXEC) && (kind_r == skl_pkg::KIND_INSERT) && !full;
    ctrl.del_en = (state_r == S_EXEC) && (kind_r == skl_pkg::KIND_DELETE) && found;
  end

  for (genvar i = 0; i < skl_pkg::CAPACITY; i++) begin : g_cell
    skl_cell u_cell (
      .clk       (clk),
      .idx       (skl_pkg::idx_t'(i)),
      .ctrl      (ctrl),
      .in_key    (in_ch.key),
      .ins_key   (key_r),
      .count     (count_r),
      .left_key  ((i == 0) ? key_r : cell_key[(i == 0) ? 0 : i-1]),
      .right_key ((i == skl_pkg::CAPACITY-1) ? cell_key[i]
                                             : cell_key[(i == skl_pkg::CAPACITY-1) ? i : i+1]),
      .left_h    ((i == 0) ? 1'b0 : h_vec[(i == 0) ? 0 : i-1]),
      .left_d    ((i == 0) ? 1'b0 : d_vec[(i == 0) ? 0 : i-1]),
      .key_o     (cell_key[i]),
      .h_o       (h_vec[i]),
      .d_o       (d_vec[i]),
      .bnd_o     (bnd_vec[i])
    );
  end

  // Exactly one boundary cell at most; OR its index out.
  always_comb begin
    bnd_idx = '0;
    for (int i = 0; i < skl_pkg::CAPACITY; i++) begin
      if (bnd_vec[i]) begin
        bnd_idx = bnd_idx | skl_pkg::idx_t'(i);
      end
    end
  end

  always_comb begin
    count_nxt = count_r;
    pos_nxt   = '0;
    if (kind_r == skl_pkg::KIND_INSERT) begin
      if (full) begin
        status_nxt = skl_pkg::ST_FULL;
      end else begin
        status_nxt = skl_pkg::ST_INSERTED;
        pos_nxt    = bnd_idx;
        count_nxt  = count_r + skl_pkg::cnt_t'(1);
      end
    end else begin
      if (found) begin
        status_nxt = skl_pkg::ST_DELETED;
        pos_nxt    = bnd_idx;
        count_nxt  = count_r - skl_pkg::cnt_t'(1);
      end else begin
        status_nxt = skl_pkg::ST_NOT_FOUND;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            state_r <= S_EXEC;
          end
        end
        S_EXEC: begin
          state_r     <= S_IDLE;
          count_r     <= count_nxt;
          out_valid_r <= 1'b1;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      kind_r <= in_ch.kind;
      key_r  <= in_ch.key;
    end
    if (state_r == S_EXEC) begin
      status_r    <= status_nxt;
      pos_r       <= skl_pkg::POS_W'(pos_nxt);
      entry_cnt_r <= skl_pkg::COUNT_W'(count_nxt);
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.status      = status_r;
  assign out_ch.position    = pos_r;
  assign out_ch.entry_count = entry_cnt_r;

endmodule
